@@ hw/rtl/checkerboard_box_filtered_blend_top_macros.svh @@
// Assertion macros for the checkerboard blend block.
`ifndef CHECKERBOARD_BOX_FILTERED_BLEND_TOP_MACROS_SVH
`define CHECKERBOARD_BOX_FILTERED_BLEND_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CB_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define CB_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define CB_ASSERT_IMP(label, pre, post, msg)
`define CB_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ hw/rtl/cbblend_pkg.sv @@
// Types, constants and helpers for the checkerboard blend block.
`default_nettype none
package cbblend_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int TEXEL_BITS = 16;
    localparam int W_W        = FRAC_BITS + 1;   // weight, one = 2^FRAC_BITS
    localparam int REM_W      = FRAC_BITS + 2;   // divider remainder / divisor
    localparam int Q_W        = FRAC_BITS + 1;   // quotient bits, one per stage
    localparam int P_W        = 2 * W_W;         // si*ti product
    localparam int M_W        = W_W + TEXEL_BITS;
    localparam logic [W_W-1:0] ONE_W  = W_W'(1) << FRAC_BITS;
    localparam logic [W_W-1:0] HALF_W = W_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [31:0]    s_coord;
        logic signed [31:0]    t_coord;
        logic signed [31:0]    ds_dx;
        logic signed [31:0]    ds_dy;
        logic signed [31:0]    dt_dx;
        logic signed [31:0]    dt_dy;
        logic [TEXEL_BITS-1:0] tex_a;
        logic [TEXEL_BITS-1:0] tex_b;
    } t_in_item;

    typedef struct packed {
        logic [TEXEL_BITS-1:0] texel_value;
        logic [W_W-1:0]        weight_b;
    } t_out_item;

    // Sideband and divider state carried through the divider stages.
    typedef struct packed {
        logic [TEXEL_BITS-1:0] ta;
        logic [TEXEL_BITS-1:0] tb;
        logic                  aa;
        logic                  odd;
        logic                  same;
        logic                  wide;
        logic                  zs;
        logic                  zt;
        logic                  ps;
        logic                  pt;
        logic [REM_W-1:0]      dvs;
        logic [REM_W-1:0]      dvt;
        logic [REM_W-1:0]      rs;
        logic [REM_W-1:0]      rt;
        logic [Q_W-1:0]        qs;
        logic [Q_W-1:0]        qt;
    } t_mid;

    function automatic logic [32:0] abs33(input logic signed [31:0] x);
        logic signed [32:0] e;
        e = {x[31], x};
        return e[32] ? 33'(-e) : 33'(e);
    endfunction

    // c +/- d, saturated to the signed 32-bit range
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                   input logic [32:0] d,
                                                   input logic neg);
        logic signed [34:0] ce;
        logic signed [34:0] de;
        logic signed [34:0] sum;
        ce  = {{3{c[31]}}, c};
        de  = {2'b00, d};
        sum = neg ? (ce - de) : (ce + de);
        if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
            return sum[31:0];
        end
        return sum[34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    // Integral of the checker step from 0 to x
    function automatic logic signed [32:0] bump(input logic signed [31:0] x);
        logic signed [32:0] hs;
        logic [FRAC_BITS:0] r;
        logic [32:0]        add;
        hs  = {{2{x[31]}}, x[31:FRAC_BITS+1], {FRAC_BITS{1'b0}}};
        r   = x[FRAC_BITS:0];
        add = (r[FRAC_BITS] && (|r[FRAC_BITS-1:0]))
            ? {{(33-FRAC_BITS){1'b0}}, r[FRAC_BITS-1:0]} : 33'd0;
        return hs + $signed(add);
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/checkerboard_box_filtered_blend_top.sv @@
// Top level of the box-filtered checkerboard blend pipeline.
// Registers in order: stages 1 to 3, the divider stages, then post 1 to post 4 (Q16.16).
// Throughput: one item per cycle while the output is not stalled; the restoring
// divider gives one quotient bit per stage, FRAC_BITS + 1 stages for each axis running side by side.
// A stall while the output holds a valid item freezes the whole pipeline and stalls the input.
// Synchronous active-low reset clears all valid bits and sets aa_mode to 1.
`default_nettype none
`include "checkerboard_box_filtered_blend_top_macros.svh"
module checkerboard_box_filtered_blend_top
    import cbblend_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);
    // Single global advance: every stage moves unless the output holds an item
    // that downstream is not taking.
    logic en;
    assign en          = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    logic r_aa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aa <= 1'b1;
        end else if (i_cfg_valid) begin
            r_aa <= i_cfg_data;
        end
    end

    // ---------------- stage 1: half widths and check parity ----------------
    logic                  r_v1;
    logic signed [31:0]    r1_s, r1_t;
    logic [32:0]           r1_ds, r1_dt;
    logic [TEXEL_BITS-1:0] r1_ta, r1_tb;
    logic                  r1_aa, r1_odd;
    logic [32:0]           n_ax, n_ay, n_bx, n_by;

    always_comb begin
        n_ax = abs33(i_in_item.ds_dx);
        n_ay = abs33(i_in_item.ds_dy);
        n_bx = abs33(i_in_item.dt_dx);
        n_by = abs33(i_in_item.dt_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_s   <= i_in_item.s_coord;
            r1_t   <= i_in_item.t_coord;
            r1_ds  <= (n_ay > n_ax) ? n_ay : n_ax;
            r1_dt  <= (n_by > n_bx) ? n_by : n_bx;
            r1_ta  <= i_in_item.tex_a;
            r1_tb  <= i_in_item.tex_b;
            r1_aa  <= r_aa;
            // floor(s)+floor(t) is odd when the unit bits differ
            r1_odd <= i_in_item.s_coord[FRAC_BITS] ^ i_in_item.t_coord[FRAC_BITS];
        end
    end

    // ---------------- stage 2: saturated window ends ----------------
    logic                  r_v2;
    logic signed [31:0]    r2_s0, r2_s1, r2_t0, r2_t1;
    logic [TEXEL_BITS-1:0] r2_ta, r2_tb;
    logic                  r2_aa, r2_odd, r2_wide, r2_zs, r2_zt, r2_ps, r2_pt;
    logic [REM_W-1:0]      r2_dvs, r2_dvt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s0   <= sat_add(r1_s, r1_ds, 1'b1);
            r2_s1   <= sat_add(r1_s, r1_ds, 1'b0);
            r2_t0   <= sat_add(r1_t, r1_dt, 1'b1);
            r2_t1   <= sat_add(r1_t, r1_dt, 1'b0);
            r2_ta   <= r1_ta;
            r2_tb   <= r1_tb;
            r2_aa   <= r1_aa;
            r2_odd  <= r1_odd;
            r2_wide <= (r1_ds > 33'(ONE_W)) || (r1_dt > 33'(ONE_W));
            r2_zs   <= (r1_ds == 33'd0);
            r2_zt   <= (r1_dt == 33'd0);
            r2_ps   <= r1_s[FRAC_BITS];
            r2_pt   <= r1_t[FRAC_BITS];
            // 2*d; only meaningful when d <= one, otherwise the result is unused
            r2_dvs  <= {r1_ds[REM_W-2:0], 1'b0};
            r2_dvt  <= {r1_dt[REM_W-2:0], 1'b0};
        end
    end

    // ---------------- stage 3: bump differences ----------------
    logic signed [32:0] n_dfs, n_dft;
    t_mid               n_m0;

    always_comb begin
        n_dfs        = bump(r2_s1) - bump(r2_s0);
        n_dft        = bump(r2_t1) - bump(r2_t0);
        n_m0.ta      = r2_ta;
        n_m0.tb      = r2_tb;
        n_m0.aa      = r2_aa;
        n_m0.odd     = r2_odd;
        n_m0.same    = (r2_s0[31:FRAC_BITS] == r2_s1[31:FRAC_BITS]) &&
                       (r2_t0[31:FRAC_BITS] == r2_t1[31:FRAC_BITS]);
        n_m0.wide    = r2_wide;
        n_m0.zs      = r2_zs;
        n_m0.zt      = r2_zt;
        n_m0.ps      = r2_ps;
        n_m0.pt      = r2_pt;
        n_m0.dvs     = r2_dvs;
        n_m0.dvt     = r2_dvt;
        n_m0.rs      = n_dfs[32] ? '0 : n_dfs[REM_W-1:0];
        n_m0.rt      = n_dft[32] ? '0 : n_dft[REM_W-1:0];
        n_m0.qs      = '0;
        n_m0.qt      = '0;
    end

    // ---------------- divider stages: one quotient bit each ----------------
    logic r_dv [Q_W+1];
    t_mid r_dm [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm[0] <= n_m0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        t_mid             n_nx;
        logic [REM_W-1:0] n_as, n_at;

        always_comb begin
            // the first step takes the integer bit without doubling
            n_as = (k == 0) ? r_dm[k].rs : {r_dm[k].rs[REM_W-2:0], 1'b0};
            n_at = (k == 0) ? r_dm[k].rt : {r_dm[k].rt[REM_W-2:0], 1'b0};
            n_nx = r_dm[k];
            if (n_as >= r_dm[k].dvs) begin
                n_nx.rs = n_as - r_dm[k].dvs;
                n_nx.qs = {r_dm[k].qs[Q_W-2:0], 1'b1};
            end else begin
                n_nx.rs = n_as;
                n_nx.qs = {r_dm[k].qs[Q_W-2:0], 1'b0};
            end
            if (n_at >= r_dm[k].dvt) begin
                n_nx.rt = n_at - r_dm[k].dvt;
                n_nx.qt = {r_dm[k].qt[Q_W-2:0], 1'b1};
            end else begin
                n_nx.rt = n_at;
                n_nx.qt = {r_dm[k].qt[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dm[k+1] <= n_nx;
            end
        end
    end

    // ---------------- post 1: axis averages and their product ----------------
    t_mid                  dm_last;
    logic [W_W-1:0]        n_si, n_ti;
    logic                  r_vp1;
    logic [W_W-1:0]        rp1_si, rp1_ti;
    logic [P_W-1:0]        rp1_prod;
    logic [TEXEL_BITS-1:0] rp1_ta, rp1_tb;
    logic                  rp1_aa, rp1_odd, rp1_same, rp1_wide;

    always_comb begin
        dm_last = r_dm[Q_W];
        if (dm_last.zs) begin
            n_si = dm_last.ps ? ONE_W : '0;
        end else begin
            n_si = (dm_last.qs > ONE_W) ? ONE_W : dm_last.qs;
        end
        if (dm_last.zt) begin
            n_ti = dm_last.pt ? ONE_W : '0;
        end else begin
            n_ti = (dm_last.qt > ONE_W) ? ONE_W : dm_last.qt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp1 <= 1'b0;
        end else if (en) begin
            r_vp1 <= r_dv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp1_si   <= n_si;
            rp1_ti   <= n_ti;
            rp1_prod <= n_si * n_ti;
            rp1_ta   <= dm_last.ta;
            rp1_tb   <= dm_last.tb;
            rp1_aa   <= dm_last.aa;
            rp1_odd  <= dm_last.odd;
            rp1_same <= dm_last.same;
            rp1_wide <= dm_last.wide;
        end
    end

    // ---------------- post 2: weight and case selection ----------------
    logic signed [W_W+2:0] n_wr;
    logic [W_W-1:0]        n_wc, n_w;
    logic                  r_vp2;
    logic [W_W-1:0]        rp2_w;
    logic [TEXEL_BITS-1:0] rp2_ta, rp2_tb;

    always_comb begin
        // si + ti - floor(2*si*ti / one)
        n_wr = $signed({3'b000, rp1_si}) + $signed({3'b000, rp1_ti})
             - $signed({1'b0, rp1_prod[P_W-1:FRAC_BITS-1]});
        if (n_wr < 0) begin
            n_wc = '0;
        end else if (n_wr > $signed({3'b000, ONE_W})) begin
            n_wc = ONE_W;
        end else begin
            n_wc = n_wr[W_W-1:0];
        end
        if (!rp1_aa || rp1_same) begin
            n_w = rp1_odd ? ONE_W : '0;
        end else if (rp1_wide) begin
            n_w = HALF_W;
        end else begin
            n_w = n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp2 <= 1'b0;
        end else if (en) begin
            r_vp2 <= r_vp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp2_w  <= n_w;
            rp2_ta <= rp1_ta;
            rp2_tb <= rp1_tb;
        end
    end

    // ---------------- post 3: blend products ----------------
    logic                  r_vp3;
    logic [M_W-1:0]        rp3_ma, rp3_mb;
    logic [W_W-1:0]        rp3_w;
    logic [TEXEL_BITS-1:0] rp3_ta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp3 <= 1'b0;
        end else if (en) begin
            r_vp3 <= r_vp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp3_ma <= (ONE_W - rp2_w) * rp2_ta;
            rp3_mb <= rp2_w * rp2_tb;
            rp3_w  <= rp2_w;
            rp3_ta <= rp2_ta;
        end
    end

    // ---------------- post 4: round and output register ----------------
    logic [M_W:0]          n_sum;
    logic                  r_vp4;
    t_out_item             r_out;
    logic [TEXEL_BITS-1:0] r_out_ta;

    assign n_sum = {1'b0, rp3_ma} + {1'b0, rp3_mb} + (M_W+1)'(HALF_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp4 <= 1'b0;
        end else if (en) begin
            r_vp4 <= r_vp3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.texel_value <= n_sum[FRAC_BITS+TEXEL_BITS-1:FRAC_BITS];
            r_out.weight_b    <= rp3_w;
            r_out_ta          <= rp3_ta;
        end
    end

    assign o_out_valid = r_vp4;
    assign o_out_item  = r_out;

    // ---------------- checks ----------------
    `CB_ASSERT_NEVER(a_weight_range, o_out_valid && (o_out_item.weight_b > ONE_W), "weight above one")
    `CB_ASSERT_IMP(a_zero_weight_texel, o_out_valid && (o_out_item.weight_b == '0), o_out_item.texel_value == r_out_ta, "zero weight must pass tex_a")
    `CB_ASSERT_IMP(a_quot_range, r_dv[Q_W] && dm_last.aa && !dm_last.wide && !dm_last.zs, dm_last.qs <= ONE_W, "s quotient above one")
    `CB_ASSERT_IMP(a_frozen_when_stalled, o_out_valid && i_out_stall, o_in_stall, "input taken while output stalled")
endmodule
`default_nettype wire

@@ bench/checkerboard_box_filtered_blend_checker.sv @@
// Checker for the checkerboard blend block: predicts each result and compares.
`timescale 1ns / 1ps
module checkerboard_box_filtered_blend_checker
    import cbblend_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_ready,
    input  wire logic      i_cfg_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_results_seen
);
    localparam longint ONE = longint'(1) << FRAC_BITS;

    logic      aa_mode_copy;
    t_out_item blend_expected[$];

    function automatic longint floor_frac(input longint x, input int sh);
        return x >>> sh;
    endfunction

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint step_area(input longint x);
        longint h;
        longint e;
        h = floor_frac(x, FRAC_BITS + 1);
        e = x - h * 2 * ONE - ONE;
        return h * ONE + (e > 0 ? e : 0);
    endfunction

    // average checker coverage along one axis of the filter window
    function automatic longint axis_cover(input longint c, input longint d,
                                          input longint lo, input longint hi);
        longint diff;
        longint q;
        if (d == 0) return floor_frac(c, FRAC_BITS) & 1 ? ONE : 0;
        diff = step_area(hi) - step_area(lo);
        if (diff < 0) diff = 0;
        q = (diff << FRAC_BITS) / (2 * d);
        return q > ONE ? ONE : q;
    endfunction

    function automatic longint mag(input logic signed [31:0] v);
        longint x;
        x = longint'(v);
        return x < 0 ? -x : x;
    endfunction

    function automatic t_out_item predict_blend(input t_in_item it, input logic aa);
        longint s, t, ds, dt, w, si, ti, s0, s1, t0, t1;
        logic odd;
        t_out_item r;
        s  = longint'(it.s_coord);
        t  = longint'(it.t_coord);
        ds = mag(it.ds_dx) > mag(it.ds_dy) ? mag(it.ds_dx) : mag(it.ds_dy);
        dt = mag(it.dt_dx) > mag(it.dt_dy) ? mag(it.dt_dx) : mag(it.dt_dy);
        odd = ((floor_frac(s, FRAC_BITS) + floor_frac(t, FRAC_BITS)) & 1) != 0;
        if (!aa) begin
            w = odd ? ONE : 0;
        end else begin
            s0 = sat32(s - ds);
            s1 = sat32(s + ds);
            t0 = sat32(t - dt);
            t1 = sat32(t + dt);
            if (floor_frac(s0, FRAC_BITS) == floor_frac(s1, FRAC_BITS) &&
                floor_frac(t0, FRAC_BITS) == floor_frac(t1, FRAC_BITS)) begin
                w = odd ? ONE : 0;
            end else if (ds > ONE || dt > ONE) begin
                w = ONE / 2;
            end else begin
                si = axis_cover(s, ds, s0, s1);
                ti = axis_cover(t, dt, t0, t1);
                w = si + ti - ((2 * si * ti) >> FRAC_BITS);
                if (w < 0) w = 0;
                if (w > ONE) w = ONE;
            end
        end
        r.weight_b    = W_W'(w);
        r.texel_value = TEXEL_BITS'(((ONE - w) * longint'(it.tex_a)
                        + w * longint'(it.tex_b) + ONE / 2) >> FRAC_BITS);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            aa_mode_copy   <= 1'b1;
            o_fail_count   <= 0;
            o_results_seen <= 0;
            blend_expected.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                blend_expected.push_back(predict_blend(i_in_item, aa_mode_copy));
            if (i_cfg_valid && i_cfg_ready) aa_mode_copy <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (blend_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = blend_expected.pop_front();
                    if (exp_item.texel_value !== i_out_item.texel_value ||
                        exp_item.weight_b !== i_out_item.weight_b) begin
                        $display("%0t: mismatch expected texel %h weight %h, got texel %h weight %h",
                                 $time, exp_item.texel_value, exp_item.weight_b,
                                 i_out_item.texel_value, i_out_item.weight_b);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= blend_expected.size();
    end
endmodule

@@ bench/checkerboard_box_filtered_blend_top_test.sv @@
// Testbench top for the checkerboard blend block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module checkerboard_box_filtered_blend_top_test;
    import cbblend_pkg::*;

    localparam int LATENCY   = FRAC_BITS + 8;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 1100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct = 0;   // percent of cycles the sender holds valid low
    int recv_stall_pct = 0;  // percent of cycles the receiver stalls
    int hold_cycles = 0;     // long receiver hold-off, counted down below
    int quiet_cycles = 0;
    int items_sent = 0;
    int cfg_writes = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    checkerboard_box_filtered_blend_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    checkerboard_box_filtered_blend_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_item     (out_item),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // Receiver: random stall, or a long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: cycles with no accepted item on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random Q16.16 value, mostly near the origin, sometimes anywhere.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            default: return 32'($signed($urandom_range(64 << 16)) - (32 << 16));
        endcase
    endfunction

    // Derivatives: zero, inside a check, up to one, just past one, or wild.
    function automatic logic [31:0] rand_deriv();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = $urandom_range(1 << 12);
            2, 3, 4: v = $urandom_range(1 << FRAC_BITS);
            5: v = $urandom_range(1 << FRAC_BITS, 3 << FRAC_BITS);
            6: v = $urandom();
            default: v = $urandom_range(1 << 15);
        endcase
        return $urandom_range(1) ? -v : v;
    endfunction

    // Valid stays high between back-to-back items; it drops only on idle cycles.
    task automatic send_lookup(input t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        t_in_item it;
        it.s_coord = rand_coord();
        it.t_coord = rand_coord();
        it.ds_dx   = rand_deriv();
        it.ds_dy   = rand_deriv();
        it.dt_dx   = rand_deriv();
        it.dt_dy   = rand_deriv();
        it.tex_a   = $urandom();
        it.tex_b   = $urandom();
        send_lookup(it);
    endtask

    task automatic send_fields(input logic [31:0] s, input logic [31:0] t,
                               input logic [31:0] d, input logic [15:0] a,
                               input logic [15:0] b);
        t_in_item it;
        it = '{s, t, d, d, d, d, a, b};
        send_lookup(it);
    endtask

    // Drain, let the pipeline settle, then write aa_mode.
    task automatic set_aa_mode(input logic mode);
        drain();
        repeat (LATENCY + 2) @(posedge i_clk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_random();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset mode is box filtering.
        send_fields(32'h0000_8000, 32'h0000_8000, 32'h0000_0000, 16'h1234, 16'hABCD);
        send_fields(32'h0001_8000, 32'h0000_8000, 32'h0000_1000, 16'hFFFF, 16'h0000);
        send_fields(32'hFFFF_8000, 32'h0000_8000, 32'h0000_0000, 16'h0000, 16'hFFFF);
        send_fields(32'h0000_F000, 32'h0000_F000, 32'h0000_2000, 16'h8000, 16'h7FFF);
        send_fields(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hFFFF, 16'hFFFF);
        send_fields(32'h0001_0000, 32'h0000_8000, 32'h0001_0001, 16'h1111, 16'hEEEE);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hAAAA, 16'h5555);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h5555, 16'hAAAA);
        send_fields(32'h7FFF_F000, 32'h8000_0000, 32'h0000_4000, 16'h0001, 16'hFFFE);
        send_fields(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_C000, 16'h00FF, 16'hFF00);
        send_fields(32'h0002_8000, 32'h0001_0000, 32'h0000_0000, 16'hC3C3, 16'h3C3C);
        begin
            t_in_item it;
            // zero width on s only, t straddles a check edge
            it = '{32'h0001_4000, 32'h0000_F800, 0, 0, 32'h0000_1000,
                   32'hFFFF_E000, 16'h0F0F, 16'hF0F0};
            send_lookup(it);
            it = '{32'hFFFE_C000, 32'h0003_0400, 32'h0000_3000, 32'hFFFF_A000,
                   0, 0, 16'h7777, 16'h9999};
            send_lookup(it);
        end
        set_aa_mode(1'b0);
        send_fields(32'h0000_8000, 32'h0000_8000, 32'h0000_F000, 16'h1234, 16'hABCD);
        send_fields(32'h0001_8000, 32'h0000_8000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000);
        send_fields(32'hFFFF_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'hFFFF);
        send_fields(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF);

        // Random phases over both modes and all idling patterns.
        run_phase(150, 0, 0);
        set_aa_mode(1'b1);
        run_phase(200, 0, 0);
        run_phase(150, 53, 0);
        run_phase(150, 0, 53);
        run_phase(150, 25, 25);

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 4 * LATENCY;
        run_phase(80, 0, 0);

        // Sender pauses until every result is back.
        drain();
        set_aa_mode(1'b0);
        run_phase(80, 25, 25);
        set_aa_mode(1'b1);
        run_phase(140, 0, 0);

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Sent %0d lookups in both filter modes, %0d mode writes, %0d results checked.",
                 items_sent, cfg_writes, results_seen);
        $display("Idling phases: none, sender, receiver, both, long output hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cbblend_pkg.sv
hw/rtl/checkerboard_box_filtered_blend_top.sv
bench/checkerboard_box_filtered_blend_checker.sv
bench/checkerboard_box_filtered_blend_top_test.sv
